@@ rtl/dttf_pkg.sv @@
package dttf_pkg;

  localparam int ACC_W   = 32;
  localparam int FRAC_W  = 30;
  localparam int CNT_W   = 4;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic clear;
  } acc_ctrl_t;

  function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [FRAC_W-1:0] v;
    unique case (n)
      4'd0:    v = 30'd1;
      4'd1:    v = 30'd10;
      4'd2:    v = 30'd100;
      4'd3:    v = 30'd1000;
      4'd4:    v = 30'd10000;
      4'd5:    v = 30'd100000;
      4'd6:    v = 30'd1000000;
      4'd7:    v = 30'd10000000;
      4'd8:    v = 30'd100000000;
      4'd9:    v = 30'd1000000000;
      default: v = 30'd1;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/dttf_acc.sv @@
module dttf_acc #(
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dttf_pkg::acc_ctrl_t               ctrl,
  input  logic [dttf_pkg::CHAR_W-1:0]       character,
  output logic                              sign_seen,
  output logic [dttf_pkg::ACC_W-1:0]        whole_accum,
  output logic [dttf_pkg::FRAC_W-1:0]       frac_accum,
  output logic [dttf_pkg::CNT_W-1:0]        frac_digit_count
);

  logic                          sign_seen_r, sign_seen_nxt;
  logic                          in_fraction_r, in_fraction_nxt;
  logic [dttf_pkg::ACC_W-1:0]    whole_r, whole_nxt;
  logic [dttf_pkg::FRAC_W-1:0]   frac_r, frac_nxt;
  logic [dttf_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [dttf_pkg::CHAR_W-1:0]   char_off;

  assign is_digit = (character >= dttf_pkg::CHAR_ZERO) && (character <= dttf_pkg::CHAR_NINE);
  assign char_off = character - dttf_pkg::CHAR_ZERO;
  assign digit    = char_off[3:0];

  always_comb begin
    sign_seen_nxt   = sign_seen_r;
    in_fraction_nxt = in_fraction_r;
    whole_nxt       = whole_r;
    frac_nxt        = frac_r;
    count_nxt       = count_r;
    if (ctrl.clear) begin
      sign_seen_nxt   = 1'b0;
      in_fraction_nxt = 1'b0;
      whole_nxt       = '0;
      frac_nxt        = '0;
      count_nxt       = '0;
    end else if (ctrl.take) begin
      if (character == dttf_pkg::CHAR_MINUS) begin
        sign_seen_nxt = 1'b1;
      end else if (character == dttf_pkg::CHAR_DOT) begin
        in_fraction_nxt = 1'b1;
      end else if (is_digit) begin
        if (!in_fraction_r) begin
          whole_nxt = {whole_r[dttf_pkg::ACC_W-4:0], 3'b000}
                    + {whole_r[dttf_pkg::ACC_W-2:0], 1'b0}
                    + {{(dttf_pkg::ACC_W-4){1'b0}}, digit};
        end else if (count_r < dttf_pkg::CNT_W'(MAX_FRAC_DIGITS)) begin
          frac_nxt  = {frac_r[dttf_pkg::FRAC_W-4:0], 3'b000}
                    + {frac_r[dttf_pkg::FRAC_W-2:0], 1'b0}
                    + {{(dttf_pkg::FRAC_W-4){1'b0}}, digit};
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_seen_r   <= 1'b0;
      in_fraction_r <= 1'b0;
      whole_r       <= '0;
      frac_r        <= '0;
      count_r       <= '0;
    end else begin
      sign_seen_r   <= sign_seen_nxt;
      in_fraction_r <= in_fraction_nxt;
      whole_r       <= whole_nxt;
      frac_r        <= frac_nxt;
      count_r       <= count_nxt;
    end
  end

  assign sign_seen        = sign_seen_r;
  assign whole_accum      = whole_r;
  assign frac_accum       = frac_r;
  assign frac_digit_count = count_r;

endmodule

@@ rtl/dttf_div.sv @@
module dttf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dttf_pkg::FRAC_W-1:0]   numer,
  input  logic [dttf_pkg::FRAC_W-1:0]   denom,
  output logic                          last_step,
  output logic [FRAC_BITS-1:0]          quotient
);

  localparam int CW = $clog2(FRAC_BITS);

  logic                          run_r, run_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [dttf_pkg::FRAC_W-1:0]   rem_r, rem_nxt;
  logic [dttf_pkg::FRAC_W-1:0]   den_r, den_nxt;
  logic [FRAC_BITS-1:0]          quo_r, quo_nxt;
  logic [dttf_pkg::FRAC_W:0]     rem_sh;
  logic [dttf_pkg::FRAC_W+1:0]   diff;
  logic                          fits;

  assign rem_sh = {rem_r, 1'b0};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign fits   = !diff[dttf_pkg::FRAC_W+1];
  assign last_step = run_r && (cnt_r == '0);

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    quo_nxt = quo_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(FRAC_BITS - 1);
      rem_nxt = numer;
      den_nxt = denom;
      quo_nxt = '0;
    end else if (run_r) begin
      rem_nxt = fits ? diff[dttf_pkg::FRAC_W-1:0] : rem_sh[dttf_pkg::FRAC_W-1:0];
      quo_nxt = {quo_r[FRAC_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

@@ rtl/decimal_text_to_fixed_point.sv @@
// Each character request without the last flag is taken without a stall.
// A request with the last flag moves through the LOAD, DIV and DONE states
// before the result is registered: LOAD starts the shift-subtract divider,
// DIV takes one quotient bit per cycle from it and DONE registers the result.
// Input stalls until the result is loaded.
// Synchronous active-low reset clears all accumulators and the result valid.
module decimal_text_to_fixed_point #(
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_character,
  input  logic                    in_last_char,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_is_negative,
  output logic [31:0]             out_whole_part,
  output logic [FRAC_BITS-1:0]    out_fraction_bits
);

  dttf_pkg::state_t              state_r, state_nxt;
  dttf_pkg::acc_ctrl_t           acc_ctrl;
  logic                          div_start;
  logic                          div_last;
  logic                          out_load;
  logic                          out_valid_r, out_valid_nxt;
  logic                          sign_seen;
  logic [dttf_pkg::ACC_W-1:0]    whole_accum;
  logic [dttf_pkg::FRAC_W-1:0]   frac_accum;
  logic [dttf_pkg::CNT_W-1:0]    frac_count;
  logic [FRAC_BITS-1:0]          quotient;
  logic                          neg_r;
  logic [dttf_pkg::ACC_W-1:0]    whole_r;
  logic [FRAC_BITS-1:0]          frac_bits_r;

  always_comb begin
    state_nxt     = state_r;
    in_stall      = 1'b1;
    div_start     = 1'b0;
    out_load      = 1'b0;
    acc_ctrl.take = 1'b0;
    acc_ctrl.clear = 1'b0;
    unique case (state_r)
      dttf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        acc_ctrl.take = in_valid;
        if (in_valid && in_last_char) begin
          state_nxt = dttf_pkg::ST_LOAD;
        end
      end
      dttf_pkg::ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = dttf_pkg::ST_DIV;
      end
      dttf_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = dttf_pkg::ST_DONE;
        end
      end
      dttf_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load       = 1'b1;
          acc_ctrl.clear = 1'b1;
          state_nxt      = dttf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dttf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dttf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      neg_r       <= sign_seen;
      whole_r     <= whole_accum;
      frac_bits_r <= quotient;
    end
  end

  dttf_acc #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_acc (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (acc_ctrl),
    .character        (in_character),
    .sign_seen        (sign_seen),
    .whole_accum      (whole_accum),
    .frac_accum       (frac_accum),
    .frac_digit_count (frac_count)
  );

  dttf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .numer     (frac_accum),
    .denom     (dttf_pkg::pow10(frac_count)),
    .last_step (div_last),
    .quotient  (quotient)
  );

  assign out_valid         = out_valid_r;
  assign out_is_negative   = neg_r;
  assign out_whole_part    = whole_r;
  assign out_fraction_bits = frac_bits_r;

endmodule

@@ rtl/dttf_checker.sv @@
module dttf_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_last_char,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_is_negative,
  input logic [31:0]             out_whole_part,
  input logic [FRAC_BITS-1:0]    out_fraction_bits
);

  // A stalled result request keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_negative)
      && $stable(out_whole_part) && $stable(out_fraction_bits))
    else $error("stalled result changed");

  // The final character starts the conversion, so input stalls next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_char |=> in_stall)
    else $error("input not stalled after final character");

  // Ordinary characters leave the input ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_char |=> !in_stall)
    else $error("input stalled after ordinary character");

  // A new result only appears at the end of a conversion.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a conversion");

endmodule

bind decimal_text_to_fixed_point dttf_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_dttf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_char      (in_last_char),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_is_negative   (out_is_negative),
  .out_whole_part    (out_whole_part),
  .out_fraction_bits (out_fraction_bits)
);
